@@ sv/hsvcm_pkg.sv @@
package hsvcm_pkg;

   // Fixed-point scale of the hue and saturation quantities.
   localparam int HUE_SIXTH = 3840;
   localparam int HUE_FULL  = 23040;
   localparam int SAT_ONE   = 4096;

   // Field and datapath widths.
   localparam int PIX_W  = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 13;
   localparam int QUO_W  = 13;
   localparam int NUM_W  = 21;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // One quotient bit is resolved per divider stage.
   localparam int DIV_STEPS = QUO_W;

   // Clock edges from the accepting edge to the edge that takes the result.
   localparam int RSP_LATENCY = DIV_STEPS + 4;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_HUE_LOW,
      REG_HUE_HIGH,
      REG_SAT_LOW,
      REG_SAT_HIGH,
      REG_VAL_LOW,
      REG_VAL_HIGH
   } reg_index_type;

   // Working set of one restoring division step.
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [PIX_W-1:0] den;
   } div_type;

endpackage

@@ sv/hsvcm_divider.sv @@
module hsvcm_divider (
   input  logic                        clock,
   input  hsvcm_pkg::div_type          div_in,
   output logic [hsvcm_pkg::QUO_W-1:0] quo_out,
   output logic                        rem_nz_out
);

   hsvcm_pkg::div_type stage_ff [hsvcm_pkg::DIV_STEPS];

   // Each stage tries the divisor at one bit weight, highest weight first.
   for (genvar j = 0; j < hsvcm_pkg::DIV_STEPS; j++) begin : g_step
      hsvcm_pkg::div_type              src;
      hsvcm_pkg::div_type              stage_in;
      logic [hsvcm_pkg::NUM_W-1:0]     den_shift;
      logic                            fits;

      if (j == 0) begin : g_first
         assign src = div_in;
      end else begin : g_next
         assign src = stage_ff[j-1];
      end

      always_comb begin
         den_shift = hsvcm_pkg::NUM_W'(src.den) << (hsvcm_pkg::DIV_STEPS - 1 - j);
         fits      = (src.rem >= den_shift);
         stage_in  = src;
         if (fits) begin
            stage_in.rem = src.rem - den_shift;
         end
         stage_in.quo[hsvcm_pkg::DIV_STEPS-1-j] = fits;
      end

      always_ff @(posedge clock) begin
         stage_ff[j] <= stage_in;
      end
   end

   // The last stage holds the quotient and the final remainder.
   assign quo_out    = stage_ff[hsvcm_pkg::DIV_STEPS-1].quo;
   assign rem_nz_out = |stage_ff[hsvcm_pkg::DIV_STEPS-1].rem;

endmodule

@@ sv/hsv_range_color_mask_top.sv @@
// HSV window color mask.
//
// Requests are RGB pixels on req_red_in, req_green_in and req_blue_in. A request
// is taken at each rising edge where start is high and busy is low; busy stays
// low, so a new pixel may be offered in every cycle. Each pixel is converted to
// hue, saturation and value, tested against the six window registers, and sent
// on the rsp_ ports: unchanged when it passes, black when it does not, with
// rsp_in_range telling which. rsp_strobe marks each result for one cycle, and
// the receiver must take it then; it cannot stall the block.
// Throughput is one pixel per clock. The path runs through an input register, a
// sector stage, the two 13-stage restoring dividers (hue and saturation), one
// quotient bit per stage, a hue assembly stage, and the window compare that
// feeds the output register.
// Window registers sit on the APB-style port at byte addresses 0 to 20, four
// apart: hue low, hue high, saturation low, saturation high, value low, value
// high. Reset is synchronous; it empties the pipeline and loads the full-open
// window. Registers should be written only while no pixel is in flight.
module hsv_range_color_mask_top (
   input  logic                         clock,
   input  logic                         reset,
   // Pixel requests
   input  logic                         start,
   output logic                         busy,
   input  logic [hsvcm_pkg::PIX_W-1:0]  req_red_in,
   input  logic [hsvcm_pkg::PIX_W-1:0]  req_green_in,
   input  logic [hsvcm_pkg::PIX_W-1:0]  req_blue_in,
   // Results
   output logic                         rsp_strobe,
   output logic [hsvcm_pkg::PIX_W-1:0]  rsp_red_out,
   output logic [hsvcm_pkg::PIX_W-1:0]  rsp_green_out,
   output logic [hsvcm_pkg::PIX_W-1:0]  rsp_blue_out,
   output logic                         rsp_in_range,
   // Configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hsvcm_pkg::ADDR_W-1:0] paddr,
   input  logic [hsvcm_pkg::DATA_W-1:0] pwdata,
   output logic [hsvcm_pkg::DATA_W-1:0] prdata,
   output logic                         pready
);

   localparam int PW = hsvcm_pkg::PIX_W;
   localparam int HW = hsvcm_pkg::HUE_W;
   localparam int SW = hsvcm_pkg::SAT_W;
   localparam int NW = hsvcm_pkg::NUM_W;
   localparam int DS = hsvcm_pkg::DIV_STEPS;

   // Pixel data that travels beside the dividers.
   typedef struct packed {
      logic [PW-1:0] red;
      logic [PW-1:0] green;
      logic [PW-1:0] blue;
      logic [PW-1:0] value;
      logic [HW-1:0] base;
      logic          neg;
      logic          grey;
      logic          black;
   } side_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [HW-1:0] hue_low_ff, hue_high_ff;
   logic [SW-1:0] sat_low_ff, sat_high_ff;
   logic [PW-1:0] val_low_ff, val_high_ff;
   logic          csr_write;
   hsvcm_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = hsvcm_pkg::reg_index_type'(paddr[4:2]);

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= '0;
         hue_high_ff <= HW'(hsvcm_pkg::HUE_FULL);
         sat_low_ff  <= '0;
         sat_high_ff <= SW'(hsvcm_pkg::SAT_ONE);
         val_low_ff  <= '0;
         val_high_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            hsvcm_pkg::REG_HUE_LOW:  hue_low_ff  <= pwdata[HW-1:0];
            hsvcm_pkg::REG_HUE_HIGH: hue_high_ff <= pwdata[HW-1:0];
            hsvcm_pkg::REG_SAT_LOW:  sat_low_ff  <= pwdata[SW-1:0];
            hsvcm_pkg::REG_SAT_HIGH: sat_high_ff <= pwdata[SW-1:0];
            hsvcm_pkg::REG_VAL_LOW:  val_low_ff  <= pwdata[PW-1:0];
            hsvcm_pkg::REG_VAL_HIGH: val_high_ff <= pwdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_index)
         hsvcm_pkg::REG_HUE_LOW:  prdata = hsvcm_pkg::DATA_W'(hue_low_ff);
         hsvcm_pkg::REG_HUE_HIGH: prdata = hsvcm_pkg::DATA_W'(hue_high_ff);
         hsvcm_pkg::REG_SAT_LOW:  prdata = hsvcm_pkg::DATA_W'(sat_low_ff);
         hsvcm_pkg::REG_SAT_HIGH: prdata = hsvcm_pkg::DATA_W'(sat_high_ff);
         hsvcm_pkg::REG_VAL_LOW:  prdata = hsvcm_pkg::DATA_W'(val_low_ff);
         hsvcm_pkg::REG_VAL_HIGH: prdata = hsvcm_pkg::DATA_W'(val_high_ff);
         default:                 prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic          accept;
   logic          a_valid_ff;
   logic [PW-1:0] a_red_ff, a_green_ff, a_blue_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_red_ff   <= req_red_in;
      a_green_ff <= req_green_in;
      a_blue_ff  <= req_blue_in;
   end

   // ------------------------------------------------------------------
   // Sector stage: max, min, sector, and the two dividends
   // ------------------------------------------------------------------
   logic [PW-1:0] mx, mn, spread, mag;
   logic          b_valid_ff;
   side_type      b_side_ff, b_side_in;
   logic [NW-1:0] b_hue_num_ff, b_hue_num_in;
   logic [NW-1:0] b_sat_num_ff, b_sat_num_in;
   logic [PW-1:0] b_spread_ff;

   always_comb begin
      mx = a_red_ff;
      if (a_green_ff > mx) begin
         mx = a_green_ff;
      end
      if (a_blue_ff > mx) begin
         mx = a_blue_ff;
      end
      mn = a_red_ff;
      if (a_green_ff < mn) begin
         mn = a_green_ff;
      end
      if (a_blue_ff < mn) begin
         mn = a_blue_ff;
      end
      spread = mx - mn;

      b_side_in.red   = a_red_ff;
      b_side_in.green = a_green_ff;
      b_side_in.blue  = a_blue_ff;
      b_side_in.value = mx;
      b_side_in.grey  = (spread == '0);
      b_side_in.black = (mx == '0);

      // Sector priority is red, then green, then blue.
      if (mx == a_red_ff) begin
         b_side_in.neg  = (a_green_ff < a_blue_ff);
         mag            = b_side_in.neg ? (a_blue_ff - a_green_ff)
                                        : (a_green_ff - a_blue_ff);
         b_side_in.base = b_side_in.neg ? HW'(hsvcm_pkg::HUE_FULL) : '0;
      end else if (mx == a_green_ff) begin
         b_side_in.neg  = (a_blue_ff < a_red_ff);
         mag            = b_side_in.neg ? (a_red_ff - a_blue_ff)
                                        : (a_blue_ff - a_red_ff);
         b_side_in.base = HW'(2 * hsvcm_pkg::HUE_SIXTH);
      end else begin
         b_side_in.neg  = (a_red_ff < a_green_ff);
         mag            = b_side_in.neg ? (a_green_ff - a_red_ff)
                                        : (a_red_ff - a_green_ff);
         b_side_in.base = HW'(4 * hsvcm_pkg::HUE_SIXTH);
      end

      b_hue_num_in = NW'(mag) * NW'(hsvcm_pkg::HUE_SIXTH);
      b_sat_num_in = NW'(spread) * NW'(hsvcm_pkg::SAT_ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_side_ff    <= b_side_in;
      b_hue_num_ff <= b_hue_num_in;
      b_sat_num_ff <= b_sat_num_in;
      b_spread_ff  <= spread;
   end

   // ------------------------------------------------------------------
   // Dividers: hue = 3840*|diff| / spread, saturation = 4096*spread / max
   // ------------------------------------------------------------------
   hsvcm_pkg::div_type               hue_div, sat_div;
   logic [hsvcm_pkg::QUO_W-1:0]      hue_quo, sat_quo;
   logic                             hue_rem_nz, sat_rem_nz;

   assign hue_div = '{rem: b_hue_num_ff, quo: '0, den: b_spread_ff};
   assign sat_div = '{rem: b_sat_num_ff, quo: '0, den: b_side_ff.value};

   hsvcm_divider u_hue_div (
      .clock      (clock),
      .div_in     (hue_div),
      .quo_out    (hue_quo),
      .rem_nz_out (hue_rem_nz)
   );

   hsvcm_divider u_sat_div (
      .clock      (clock),
      .div_in     (sat_div),
      .quo_out    (sat_quo),
      .rem_nz_out (sat_rem_nz)
   );

   // Side line and valid bits kept in step with the divider stages.
   logic     valid_ff [DS];
   side_type side_ff  [DS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= b_valid_ff;
         for (int k = 1; k < DS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= b_side_ff;
      for (int k = 1; k < DS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // Hue assembly stage
   // ------------------------------------------------------------------
   side_type      last_side;
   logic [HW-1:0] hue_ceil;
   logic          h_valid_ff;
   logic [HW-1:0] h_hue_ff, h_hue_in;
   logic [SW-1:0] h_sat_ff, h_sat_in;
   logic [PW-1:0] h_value_ff, h_red_ff, h_green_ff, h_blue_ff;

   assign last_side = side_ff[DS-1];

   always_comb begin
      // A negative difference floors down, so it takes the rounded-up quotient.
      hue_ceil = HW'(hue_quo) + HW'(hue_rem_nz);
      if (last_side.grey) begin
         h_hue_in = '0;
      end else if (last_side.neg) begin
         h_hue_in = last_side.base - hue_ceil;
      end else begin
         h_hue_in = last_side.base + HW'(hue_quo);
      end
      h_sat_in = last_side.black ? '0 : SW'(sat_quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= valid_ff[DS-1];
      end
   end

   always_ff @(posedge clock) begin
      h_hue_ff   <= h_hue_in;
      h_sat_ff   <= h_sat_in;
      h_value_ff <= last_side.value;
      h_red_ff   <= last_side.red;
      h_green_ff <= last_side.green;
      h_blue_ff  <= last_side.blue;
   end

   // ------------------------------------------------------------------
   // Window compare and output register
   // ------------------------------------------------------------------
   logic          pass;
   logic          rsp_strobe_ff;
   logic          rsp_in_range_ff;
   logic [PW-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   assign pass = (h_hue_ff   >= hue_low_ff) && (h_hue_ff   <= hue_high_ff) &&
                 (h_sat_ff   >= sat_low_ff) && (h_sat_ff   <= sat_high_ff) &&
                 (h_value_ff >= val_low_ff) && (h_value_ff <= val_high_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_in_range_ff <= pass;
      rsp_red_ff      <= pass ? h_red_ff   : '0;
      rsp_green_ff    <= pass ? h_green_ff : '0;
      rsp_blue_ff     <= pass ? h_blue_ff  : '0;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_in_range  = rsp_in_range_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // Every accepted request yields a result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(hsvcm_pkg::RSP_LATENCY) rsp_strobe)
      else $error("result missing after accepted request");

   // A result never appears unless a pixel sat in the hue stage in the cycle before.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(h_valid_ff))
      else $error("result without a pixel in flight");

   // The assembled hue stays below a full turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> (h_hue_ff < HW'(hsvcm_pkg::HUE_FULL)))
      else $error("hue out of range");

   // Saturation never exceeds one.
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> (h_sat_ff <= SW'(hsvcm_pkg::SAT_ONE)))
      else $error("saturation out of range");

   // A rejected pixel leaves as black.
   a_reject_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_in_range) |->
         (rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0))
      else $error("rejected pixel not black");

endmodule
